### hw/rtl/pcpg_pkg.sv
// ----------------------------------------------------------------------------
// pcpg_pkg
// Types, constants and helpers shared by the polar circle pixel generator.
// ----------------------------------------------------------------------------
package pcpg_pkg;

  localparam int unsigned QF           = 56;  // fraction bits of the series arithmetic
  localparam int unsigned TAYLOR_TERMS = 30;
  localparam int unsigned K_W          = 5;
  localparam int unsigned DSR_W        = 16;
  localparam int unsigned PIX_W        = 13;
  localparam int unsigned COLOR_W      = 24;
  localparam int unsigned OUT_W        = 56;
  localparam logic [COLOR_W-1:0] COLOR_RST = 24'h00FFFF;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STEP,
    CMD_ANGLE,
    CMD_MULX2,
    CMD_TINIT,
    CMD_TMUL,
    CMD_TDIV,
    CMD_TACC,
    CMD_TRND,
    CMD_XY
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    logic want_sin;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic k_last;
    logic emit_done;
    logic fin;
    logic rad_zero;
  } dp_sts_t;

  // Divisor of series term k: (2k)(2k+1) for sine, (2k-1)(2k) for cosine.
  function automatic logic [DSR_W-1:0] term_div(input logic [K_W-1:0] k, input logic want_sin);
    logic [DSR_W-1:0] m;
    logic [DSR_W-1:0] n;
    m = DSR_W'({k, 1'b0});
    n = want_sin ? m + DSR_W'(1) : m - DSR_W'(1);
    return m * n;
  endfunction

endpackage

### hw/rtl/polar_circle_pixel_generator.sv
// ----------------------------------------------------------------------------
// polar_circle_pixel_generator
// Polar circle rasterizer emitting eight mirrored pixels per angle step.
// ----------------------------------------------------------------------------
// Input stream: tuser is the op (0 start, 1 advance), tdata carries center_x,
// center_y and radius. A start loads the circle and, for a nonzero radius,
// emits the eight pixels at angle zero after the step division. An advance
// on an active circle evaluates cosine and sine with a 31-term series; each
// term takes one multiply and one divide in the shared units. The eight
// words of a step then go out, one per cycle while the receiver is ready.
// An advance on an idle block is taken and ignored. The output word holds
// pixel_x, pixel_y and color; tlast marks the final word of the circle.
// One item is processed at a time: the input is ready only when the block is
// idle, and a stalled receiver simply holds the current word.
// Reset returns the block to idle with the color set to 0x00FFFF. The color
// register is written by cfg_we_i and should change only while idle.
// ----------------------------------------------------------------------------
module polar_circle_pixel_generator #(
  parameter int unsigned COORD_BITS      = 11,
  parameter int unsigned ANGLE_FRAC_BITS = 20,
  parameter int unsigned TRIG_FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // center_x, center_y, radius from bit 0 up
  input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // op
  input  logic s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // pixel_x, pixel_y, color from bit 0 up
  output logic [pcpg_pkg::OUT_W-1:0] m_axis_tdata_o,
  output logic m_axis_tlast_o,
  input  logic cfg_we_i,
  input  logic [pcpg_pkg::COLOR_W-1:0] cfg_wdata_i
);
  import pcpg_pkg::*;

  localparam int unsigned IN_W = ((3*COORD_BITS+7)/8)*8;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign m_axis_tvalid_o = cmd.emit;

  pcpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (s_axis_tuser_i),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  pcpg_datapath #(
    .COORD_BITS      (COORD_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .TRIG_FRAC_BITS  (TRIG_FRAC_BITS),
    .IN_W            (IN_W)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .out_ready_i (m_axis_tready_i),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

`ifndef SYNTH
  // Output words and input acceptance never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("output valid while input ready");

  // After the final word of a circle the block is idle again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> s_axis_tready_o)
    else $error("not idle after last word");

  // A start with zero radius leaves the block ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == OP_START) &&
    (s_axis_tdata_i[3*COORD_BITS-1:2*COORD_BITS] == '0) |=> s_axis_tready_o)
    else $error("zero radius start left block busy");
`endif

endmodule

### hw/rtl/pcpg_datapath.sv
// ----------------------------------------------------------------------------
// pcpg_datapath
// Registers, shared multiplier, shared divider and pixel mirroring logic.
// ----------------------------------------------------------------------------
module pcpg_datapath #(
  parameter int unsigned COORD_BITS      = 11,
  parameter int unsigned ANGLE_FRAC_BITS = 20,
  parameter int unsigned TRIG_FRAC_BITS  = 16,
  parameter int unsigned IN_W            = 40
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [IN_W-1:0]          in_data_i,
  input  logic                     cfg_we_i,
  input  logic [pcpg_pkg::COLOR_W-1:0] cfg_wdata_i,
  input  pcpg_pkg::dp_cmd_t        cmd_i,
  input  logic                     out_ready_i,
  output pcpg_pkg::dp_sts_t        sts_o,
  output logic [pcpg_pkg::OUT_W-1:0] out_data_o,
  output logic                     out_last_o
);
  import pcpg_pkg::*;

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned AW     = ANGLE_FRAC_BITS + 2;
  localparam int unsigned SW     = ANGLE_FRAC_BITS + 1;
  localparam int unsigned TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int unsigned XY_W   = CB + 2;
  localparam int unsigned PW     = CB + 1 + TRIG_W;
  localparam int unsigned SH     = QF - TRIG_FRAC_BITS;

  logic [CB-1:0] cx_q, cy_q, r_q;
  logic [AW-1:0] angle_q;
  logic [SW-1:0] step_q;
  logic [63:0]   x2_q, term_q, pos_q, neg_q;
  logic [K_W-1:0] k_q;
  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic signed [XY_W-1:0] x_q, y_q;
  logic fin_q;
  logic [2:0] idx_q;
  logic [COLOR_W-1:0] color_q;

  // Shared 64x64 multiplier, one 32x32 partial product per cycle.
  logic [63:0]  ma_q, mb_q;
  logic [127:0] acc_q;
  logic [1:0]   mcnt_q;
  logic         mbusy_q;
  logic [63:0]  mul_res;
  logic [63:0]  pp;
  logic [6:0]   pp_sh;

  // Shared restoring divider, one quotient bit per cycle.
  logic [63:0]      dvd_q;
  logic [DSR_W-1:0] rem_q, dsr_q;
  logic [5:0]       dcnt_q;
  logic             dbusy_q;
  logic [DSR_W:0]   dtrial;
  logic             dge;

  logic [CB-1:0] in_cx, in_cy, in_r;
  logic [63:0]   a_w;
  logic [63:0]   diff, mag, rnd;
  logic signed [TRIG_W-1:0] trig_val;
  logic signed [PW-1:0] px_prod, py_prod;
  logic [PW-1:0] px_mag, py_mag, px_rnd, py_rnd;
  logic signed [XY_W-1:0] x_new, y_new;
  logic signed [XY_W-1:0] sel_a, sel_b;
  logic [PIX_W-1:0] off_a, off_b, pix_x, pix_y;
  logic handshake;

  assign in_cx = in_data_i[CB-1:0];
  assign in_cy = in_data_i[2*CB-1:CB];
  assign in_r  = in_data_i[3*CB-1:2*CB];

  assign a_w     = 64'(angle_q) << (QF - ANGLE_FRAC_BITS);
  assign mul_res = acc_q[QF+63:QF];
  assign pp      = ma_q[32*mcnt_q[0] +: 32] * mb_q[32*mcnt_q[1] +: 32];
  assign pp_sh   = {mcnt_q[0] & mcnt_q[1], mcnt_q[0] ^ mcnt_q[1], 5'b0};

  assign dtrial = {rem_q, dvd_q[63]};
  assign dge    = dtrial >= {1'b0, dsr_q};

  // Round the series sum half away from zero.
  assign diff     = pos_q - neg_q;
  assign mag      = diff[63] ? -diff : diff;
  assign rnd      = (mag + (64'(1) << (SH - 1))) >> SH;
  assign trig_val = diff[63] ? -TRIG_W'(rnd) : TRIG_W'(rnd);

  assign px_prod = PW'(signed'({1'b0, r_q})) * PW'(cos_q);
  assign py_prod = PW'(signed'({1'b0, r_q})) * PW'(sin_q);
  assign px_mag  = px_prod[PW-1] ? -px_prod : px_prod;
  assign py_mag  = py_prod[PW-1] ? -py_prod : py_prod;
  assign px_rnd  = (px_mag + (PW'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
  assign py_rnd  = (py_mag + (PW'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
  assign x_new   = px_prod[PW-1] ? -XY_W'(px_rnd) : XY_W'(px_rnd);
  assign y_new   = py_prod[PW-1] ? -XY_W'(py_rnd) : XY_W'(py_rnd);

  // Octant mirroring: the upper four words swap x and y.
  assign sel_a = idx_q[2] ? y_q : x_q;
  assign sel_b = idx_q[2] ? x_q : y_q;
  assign off_a = PIX_W'(sel_a);
  assign off_b = PIX_W'(sel_b);
  assign pix_x = PIX_W'(cx_q) + ((idx_q[1] ^ idx_q[0]) ? -off_a : off_a);
  assign pix_y = PIX_W'(cy_q) + (idx_q[1] ? -off_b : off_b);

  assign handshake  = cmd_i.emit & out_ready_i;
  assign out_data_o = OUT_W'({color_q, pix_y, pix_x});
  assign out_last_o = fin_q & (idx_q == 3'd7);

  assign sts_o.mul_done  = mbusy_q & (mcnt_q == 2'd3);
  assign sts_o.div_done  = dbusy_q & (dcnt_q == 6'd63);
  assign sts_o.k_last    = (k_q == K_W'(TAYLOR_TERMS));
  assign sts_o.emit_done = handshake & (idx_q == 3'd7);
  assign sts_o.fin       = fin_q;
  assign sts_o.rad_zero  = (in_r == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= COLOR_RST;
      mbusy_q <= 1'b0;
      dbusy_q <= 1'b0;
      mcnt_q  <= '0;
      dcnt_q  <= '0;
      idx_q   <= '0;
      k_q     <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      r_q     <= '0;
      angle_q <= '0;
      step_q  <= '0;
      x2_q    <= '0;
      term_q  <= '0;
      pos_q   <= '0;
      neg_q   <= '0;
      cos_q   <= '0;
      sin_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      fin_q   <= 1'b0;
      ma_q    <= '0;
      mb_q    <= '0;
      acc_q   <= '0;
      dvd_q   <= '0;
      rem_q   <= '0;
      dsr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
      if (mbusy_q) begin
        acc_q  <= acc_q + (128'(pp) << pp_sh);
        mcnt_q <= mcnt_q + 2'd1;
        if (mcnt_q == 2'd3) begin
          mbusy_q <= 1'b0;
        end
      end
      if (dbusy_q) begin
        rem_q  <= dge ? DSR_W'(dtrial - {1'b0, dsr_q}) : dtrial[DSR_W-1:0];
        dvd_q  <= {dvd_q[62:0], dge};
        dcnt_q <= dcnt_q + 6'd1;
        if (dcnt_q == 6'd63) begin
          dbusy_q <= 1'b0;
        end
      end
      if (handshake) begin
        idx_q <= idx_q + 3'd1;
      end
      case (cmd_i.op)
        CMD_LOAD: begin
          cx_q    <= in_cx;
          cy_q    <= in_cy;
          r_q     <= in_r;
          angle_q <= '0;
          step_q  <= '0;
          dvd_q   <= 64'(1) << ANGLE_FRAC_BITS;
          dsr_q   <= DSR_W'(in_r);
          rem_q   <= '0;
          dcnt_q  <= '0;
          dbusy_q <= (in_r != '0);
        end
        CMD_STEP: begin
          step_q <= dvd_q[SW-1:0];
          x_q    <= XY_W'(signed'({1'b0, r_q}));
          y_q    <= '0;
          fin_q  <= 1'b0;
          idx_q  <= '0;
        end
        CMD_ANGLE: begin
          angle_q <= angle_q + AW'(step_q);
        end
        CMD_MULX2: begin
          ma_q    <= a_w;
          mb_q    <= a_w;
          acc_q   <= '0;
          mcnt_q  <= '0;
          mbusy_q <= 1'b1;
        end
        CMD_TINIT: begin
          if (!cmd_i.want_sin) begin
            x2_q <= mul_res;
          end
          term_q <= cmd_i.want_sin ? a_w : (64'(1) << QF);
          pos_q  <= cmd_i.want_sin ? a_w : (64'(1) << QF);
          neg_q  <= '0;
          k_q    <= K_W'(1);
        end
        CMD_TMUL: begin
          ma_q    <= term_q;
          mb_q    <= x2_q;
          acc_q   <= '0;
          mcnt_q  <= '0;
          mbusy_q <= 1'b1;
        end
        CMD_TDIV: begin
          dvd_q   <= mul_res;
          dsr_q   <= term_div(k_q, cmd_i.want_sin);
          rem_q   <= '0;
          dcnt_q  <= '0;
          dbusy_q <= 1'b1;
        end
        CMD_TACC: begin
          term_q <= dvd_q;
          if (k_q[0]) begin
            neg_q <= neg_q + dvd_q;
          end else begin
            pos_q <= pos_q + dvd_q;
          end
          k_q <= k_q + K_W'(1);
        end
        CMD_TRND: begin
          if (cmd_i.want_sin) begin
            sin_q <= trig_val;
          end else begin
            cos_q <= trig_val;
          end
        end
        CMD_XY: begin
          x_q   <= x_new;
          y_q   <= y_new;
          fin_q <= (x_new <= y_new);
          idx_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### hw/rtl/pcpg_ctrl.sv
// ----------------------------------------------------------------------------
// pcpg_ctrl
// Sequencer that steps the datapath through setup, series and pixel output.
// ----------------------------------------------------------------------------
module pcpg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_op_i,
  input  pcpg_pkg::dp_sts_t  sts_i,
  output logic               in_ready_o,
  output pcpg_pkg::dp_cmd_t  cmd_o
);
  import pcpg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SDIV, S_STEP, S_X2, S_X2W, S_TINIT, S_TMUL, S_TMULW,
    S_TDIV, S_TDIVW, S_TACC, S_TRND, S_XY, S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   active_q, active_d;
  logic   sin_q, sin_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    sin_d        = sin_q;
    cmd_o.op     = CMD_NONE;
    cmd_o.want_sin = sin_q;
    cmd_o.emit   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_START) begin
            cmd_o.op = CMD_LOAD;
            active_d = 1'b0;
            if (!sts_i.rad_zero) begin
              state_d = S_SDIV;
            end
          end else if (active_q) begin
            cmd_o.op = CMD_ANGLE;
            state_d  = S_X2;
          end
        end
      end
      S_SDIV: if (sts_i.div_done) state_d = S_STEP;
      S_STEP: begin
        cmd_o.op = CMD_STEP;
        active_d = 1'b1;
        state_d  = S_EMIT;
      end
      S_X2: begin
        cmd_o.op = CMD_MULX2;
        sin_d    = 1'b0;
        state_d  = S_X2W;
      end
      S_X2W: if (sts_i.mul_done) state_d = S_TINIT;
      S_TINIT: begin
        cmd_o.op = CMD_TINIT;
        state_d  = S_TMUL;
      end
      S_TMUL: begin
        cmd_o.op = CMD_TMUL;
        state_d  = S_TMULW;
      end
      S_TMULW: if (sts_i.mul_done) state_d = S_TDIV;
      S_TDIV: begin
        cmd_o.op = CMD_TDIV;
        state_d  = S_TDIVW;
      end
      S_TDIVW: if (sts_i.div_done) state_d = S_TACC;
      S_TACC: begin
        cmd_o.op = CMD_TACC;
        state_d  = sts_i.k_last ? S_TRND : S_TMUL;
      end
      S_TRND: begin
        cmd_o.op = CMD_TRND;
        if (sin_q) begin
          state_d = S_XY;
        end else begin
          sin_d   = 1'b1;
          state_d = S_TINIT;
        end
      end
      S_XY: begin
        cmd_o.op = CMD_XY;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.emit_done) begin
          if (sts_i.fin) begin
            active_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= 1'b0;
      sin_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      sin_q    <= sin_d;
    end
  end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polar circle pixel generator. A behavioral
// model of the rasterizer predicts every pixel word, and a monitor compares
// the words that leave the block, field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import pcpg_pkg::*;

  localparam int unsigned CB      = 11;
  localparam int unsigned AFB     = 20;
  localparam int unsigned TFB     = 16;
  localparam int unsigned IN_W    = ((3*CB+7)/8)*8;
  // This wait covers an advance in progress with margin.
  localparam int unsigned SETTLE  = 6000;

  typedef struct packed {
    logic [PIX_W-1:0]   px;
    logic [PIX_W-1:0]   py;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [IN_W-1:0]   s_axis_tdata_i = '0;
  logic              s_axis_tuser_i = 1'b0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata_o;
  logic              m_axis_tlast_o;
  logic              cfg_we_i = 1'b0;
  logic [COLOR_W-1:0] cfg_wdata_i = '0;

  polar_circle_pixel_generator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Model state of the circle in progress.
  logic [CB-1:0]      circ_cx, circ_cy, circ_r;
  logic [AFB+1:0]     circ_angle;
  logic [AFB:0]       circ_step;
  bit                 circ_active;
  logic [COLOR_W-1:0] circ_color;

  pixel_word_t pending_pixels[$];
  int unsigned mismatch_count;
  int unsigned burst_left;

  // (a*b) >> QF, keeping the low 64 bits.
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[QF+63:QF];
  endfunction

  function automatic longint round_off(input longint v, input int unsigned sh);
    logic [63:0] half;
    logic [63:0] mag;
    half = 64'd1 << (sh - 1);
    if (v >= 0) begin
      mag = (64'(v) + half) >> sh;
      return longint'(mag);
    end
    mag = (64'(-v) + half) >> sh;
    return -longint'(mag);
  endfunction

  // Taylor series of cos or sin in Q56, rounded to TFB fraction bits.
  function automatic longint series_trig(input logic [63:0] a, input bit want_sin);
    logic [63:0] x2, term, pos, neg, d;
    x2 = qmul(a, a);
    term = want_sin ? a : (64'd1 << QF);
    pos = term;
    neg = 0;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      d = want_sin ? 64'((2*k) * (2*k + 1)) : 64'((2*k - 1) * (2*k));
      term = qmul(term, x2) / d;
      if (k % 2) neg += term;
      else pos += term;
    end
    return round_off(longint'(pos) - longint'(neg), QF - TFB);
  endfunction

  function automatic void push_octants(input longint x, input longint y, input bit fin);
    longint cx, cy;
    longint xs[8], ys[8];
    pixel_word_t w;
    cx = longint'(circ_cx);
    cy = longint'(circ_cy);
    xs = '{cx + x, cx - x, cx - x, cx + x, cx + y, cx - y, cx - y, cx + y};
    ys = '{cy + y, cy + y, cy - y, cy - y, cy + x, cy + x, cy - x, cy - x};
    for (int i = 0; i < 8; i++) begin
      w.px = PIX_W'(xs[i]);
      w.py = PIX_W'(ys[i]);
      w.color = circ_color;
      w.last = fin && (i == 7);
      pending_pixels.push_back(w);
    end
  endfunction

  function automatic void predict_pixels(input logic op, input logic [CB-1:0] cx,
                                         input logic [CB-1:0] cy, input logic [CB-1:0] r);
    longint c, s, x, y;
    if (op == OP_START) begin
      circ_cx = cx;
      circ_cy = cy;
      circ_r = r;
      circ_angle = '0;
      if (r == 0) begin
        circ_step = '0;
        circ_active = 0;
        return;
      end
      circ_step = (AFB+1)'((64'd1 << AFB) / r);
      circ_active = 1;
      push_octants(longint'(r), 0, 0);
      return;
    end
    if (!circ_active) return;
    circ_angle = circ_angle + circ_step;
    c = series_trig(64'(circ_angle) << (QF - AFB), 0);
    s = series_trig(64'(circ_angle) << (QF - AFB), 1);
    x = round_off(longint'(circ_r) * c, TFB);
    y = round_off(longint'(circ_r) * s, TFB);
    push_octants(x, y, x <= y);
    if (x <= y) circ_active = 0;
  endfunction

  // Sends one word; within a burst tvalid stays high so back-to-back words need no glitch, and a gap may drop it.
  task automatic send_item(input logic op, input logic [CB-1:0] cx,
                           input logic [CB-1:0] cy, input logic [CB-1:0] r);
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= IN_W'({r, cy, cx});
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_pixels(op, cx, cy, r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      gap = $urandom_range(0, 30);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic set_color(input logic [COLOR_W-1:0] color);
    s_axis_tvalid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= color;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    circ_color = color;
  endtask

  // Advances the current circle until it closes or the count runs out.
  task automatic run_circle(input int unsigned max_steps);
    for (int i = 0; i < max_steps && circ_active; i++)
      send_item(OP_ADVANCE, CB'($urandom), CB'($urandom), CB'($urandom));
  endtask

  task automatic test_directed();
    send_item(OP_START, 11'd100, 11'd200, 11'd1);
    run_circle(4);
    send_item(OP_ADVANCE, 11'h7FF, 11'h7FF, 11'h7FF);  // idle advance is dropped
    send_item(OP_START, 11'd5, 11'd6, 11'd0);           // zero radius draws nothing
    send_item(OP_ADVANCE, 11'd0, 11'd0, 11'd0);
    send_item(OP_START, 11'h7FF, 11'h7FF, 11'h7FF);
    run_circle(2);
    // A new start abandons the running circle; a center at zero drives
    // coordinates negative.
    send_item(OP_START, 11'd0, 11'd0, 11'd7);
    run_circle(20);
    send_item(OP_START, 11'h7FF, 11'd0, 11'd3);
    run_circle(10);
  endtask

  task automatic test_colors();
    set_color(24'h000000);
    send_item(OP_START, 11'd1000, 11'd3, 11'd2);
    run_circle(10);
    set_color(24'hFFFFFF);
    send_item(OP_START, 11'd3, 11'd2040, 11'd4);
    run_circle(10);
    set_color(24'($urandom));
  endtask

  task automatic test_random();
    int unsigned items;
    int unsigned sel;
    items = 0;
    while (items < 100) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        // Noise: large random start, left after at most one step.
        send_item(OP_START, CB'($urandom), CB'($urandom), CB'($urandom));
        run_circle($urandom_range(0, 1));
        items += 2;
      end else if (sel == 1) begin
        send_item(OP_START, CB'($urandom), CB'($urandom), 11'd0);
        items++;
      end else begin
        send_item(OP_START, CB'($urandom), CB'($urandom), CB'($urandom_range(1, 10)));
        items++;
        // Mostly finish the circle, sometimes break it off early.
        if ($urandom_range(0, 4) == 0) run_circle($urandom_range(0, 3));
        else run_circle(100);
        items += 4;
      end
      if (items == 50) set_color(24'($urandom));
    end
  endtask

  // Receiver: ready throughout some windows, randomly stalling in others.
  int unsigned stall_phase = 0;
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[9:8] == 2'd0) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(0, 9) < 6);
  end

  always @(posedge clk_i) begin
    pixel_word_t want;
    pixel_word_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.px = m_axis_tdata_o[PIX_W-1:0];
      got.py = m_axis_tdata_o[2*PIX_W-1:PIX_W];
      got.color = m_axis_tdata_o[2*PIX_W+COLOR_W-1:2*PIX_W];
      got.last = m_axis_tlast_o;
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word x=%0d y=%0d color=%06h last=%0b",
                   $signed(got.px), $signed(got.py), got.color, got.last);
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("exp x=%0d y=%0d c=%06h l=%0b got x=%0d y=%0d c=%06h l=%0b",
                     $signed(want.px), $signed(want.py), want.color, want.last,
                     $signed(got.px), $signed(got.py), got.color, got.last);
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    burst_left = 0;
    circ_cx = '0; circ_cy = '0; circ_r = '0;
    circ_angle = '0; circ_step = '0; circ_active = 0;
    circ_color = COLOR_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_colors();
    test_random();
    s_axis_tvalid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_count == 0 && pending_pixels.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
hw/rtl/pcpg_pkg.sv
hw/rtl/pcpg_datapath.sv
hw/rtl/pcpg_ctrl.sv
hw/rtl/polar_circle_pixel_generator.sv
test/tb.sv
